// ===== hdl/byte_store_deferred_commit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the byte store with deferred commit
// Clocked property wrappers, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef BYTE_STORE_DEFERRED_COMMIT_ASSERT_SVH
`define BYTE_STORE_DEFERRED_COMMIT_ASSERT_SVH

// same-cycle implication
`define BSDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsdc: same-cycle check failed");

// next-cycle implication
`define BSDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsdc: next-cycle check failed");

`endif

// ===== hdl/bsdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsdc_pkg
// Types and constants shared by the byte store controller and datapath.
// ----------------------------------------------------------------------------
package bsdc_pkg;

  localparam int ADDR_W = 16;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;

  localparam logic [7:0]       BLANK_BYTE    = 8'hFF;
  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd250;
  localparam logic [CFG_W-1:0] MAX_DEFER_RST = 16'd1500;

  // configuration register indexes
  localparam logic [0:0] CFG_DEBOUNCE  = 1'b0;
  localparam logic [0:0] CFG_MAX_DEFER = 1'b1;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clr_step;  // blank one store entry
    logic capture;   // latch input transaction, start memory read
    logic exec;      // apply the transaction, load the result
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;  // clearing pass is on its final entry
  } ctrl_sts_t;

endpackage

// ===== hdl/bsdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsdc_ctrl
// Sequencer: clearing pass after reset, then capture / execute / respond.
// ----------------------------------------------------------------------------
module bsdc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output bsdc_pkg::ctrl_cmd_t cmd,
  input  bsdc_pkg::ctrl_sts_t sts
);
  import bsdc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== hdl/bsdc_dpath.sv =====
// ----------------------------------------------------------------------------
// bsdc_dpath
// Byte memory, dirty tracking, timestamp compare and result register.
// ----------------------------------------------------------------------------
`include "byte_store_deferred_commit_assert.svh"

module bsdc_dpath #(
  parameter int STORE_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bsdc_pkg::ctrl_cmd_t           cmd,
  output bsdc_pkg::ctrl_sts_t           sts,
  input  bsdc_pkg::cmd_t                in_cmd,
  input  logic [bsdc_pkg::ADDR_W-1:0]   in_addr,
  input  logic [7:0]                    in_wdata,
  input  logic [bsdc_pkg::TIME_W-1:0]   in_now,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [bsdc_pkg::CFG_W-1:0]    cfg_wdata,
  output logic [7:0]                    res_read_data,
  output logic                          res_commit,
  output logic                          res_dirty
);
  import bsdc_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [AW-1:0] LAST_IDX = AW'(STORE_BYTES - 1);

  logic [7:0] mem [STORE_BYTES];

  cmd_t                cmd_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [7:0]          wdata_r;
  logic [TIME_W-1:0]   now_r;
  logic [7:0]          rd_data_r;

  logic [AW-1:0]       clr_cnt_r;
  logic                dirty_r, dirty_nxt;
  logic [TIME_W-1:0]   last_wr_r, last_wr_nxt;
  logic [TIME_W-1:0]   first_dirty_r, first_dirty_nxt;
  logic [CFG_W-1:0]    debounce_r, max_defer_r;
  logic [7:0]          res_rd_r, res_rd_nxt;
  logic                res_commit_r, res_commit_nxt;

  logic                in_range;
  logic [TIME_W-1:0]   quiet, held;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [7:0]          mem_wdata;

  // -- transaction capture and registered memory read
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r     <= in_cmd;
      addr_r    <= in_addr;
      wdata_r   <= in_wdata;
      now_r     <= in_now;
      rd_data_r <= mem[in_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  assign in_range  = {1'b0, addr_r} < (ADDR_W + 1)'(STORE_BYTES);
  assign mem_we    = cmd.clr_step | (cmd.exec & (cmd_r == CMD_WRITE) & in_range);
  assign mem_waddr = cmd.clr_step ? clr_cnt_r : addr_r[AW-1:0];
  assign mem_wdata = cmd.clr_step ? BLANK_BYTE : wdata_r;

  assign sts.clr_last = (clr_cnt_r == LAST_IDX);

  // elapsed times wrap modulo 2^32
  assign quiet = now_r - last_wr_r;
  assign held  = now_r - first_dirty_r;

  always_comb begin
    dirty_nxt       = dirty_r;
    last_wr_nxt     = last_wr_r;
    first_dirty_nxt = first_dirty_r;
    res_rd_nxt      = BLANK_BYTE;
    res_commit_nxt  = 1'b0;
    case (cmd_r)
      CMD_READ: begin
        if (in_range) begin
          res_rd_nxt = rd_data_r;
        end
      end
      CMD_WRITE: begin
        if (in_range) begin
          if (!dirty_r) begin
            first_dirty_nxt = now_r;
          end
          dirty_nxt   = 1'b1;
          last_wr_nxt = now_r;
        end
      end
      CMD_TICK: begin
        if (dirty_r && ((quiet >= {16'd0, debounce_r}) || (held >= {16'd0, max_defer_r})))
        begin
          dirty_nxt      = 1'b0;
          res_commit_nxt = 1'b1;
        end
      end
      CMD_FLUSH: begin
        if (dirty_r) begin
          dirty_nxt      = 1'b0;
          res_commit_nxt = 1'b1;
        end
      end
      default: begin
        res_rd_nxt = BLANK_BYTE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r     <= '0;
      dirty_r       <= 1'b0;
      last_wr_r     <= '0;
      first_dirty_r <= '0;
      debounce_r    <= DEBOUNCE_RST;
      max_defer_r   <= MAX_DEFER_RST;
      res_commit_r  <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.exec) begin
        dirty_r       <= dirty_nxt;
        last_wr_r     <= last_wr_nxt;
        first_dirty_r <= first_dirty_nxt;
        res_commit_r  <= res_commit_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE:  debounce_r  <= cfg_wdata;
          CFG_MAX_DEFER: max_defer_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_rd_r <= res_rd_nxt;
    end
  end

  assign res_read_data = res_rd_r;
  assign res_commit    = res_commit_r;
  assign res_dirty     = dirty_r;

  `BSDC_ASSERT_NOW(a_capture_alone, clk, rst_n, cmd.capture, !cmd.clr_step && !cmd.exec)
  `BSDC_ASSERT_NEXT(a_commit_cleans, clk, rst_n, cmd.exec, !(res_commit_r && dirty_r))
  `BSDC_ASSERT_NOW(a_dirty_by_write, clk, rst_n, $rose(dirty_r),
                   $past(cmd.exec) && ($past(cmd_r) == CMD_WRITE))

endmodule

// ===== hdl/byte_store_deferred_commit.sv =====
// ----------------------------------------------------------------------------
// byte_store_deferred_commit
// Byte store with deferred write-back and debounced commit requests.
// ----------------------------------------------------------------------------
// Input stream carries one command per transaction (read, write, tick,
// flush) in in_tuser, with address, data byte and millisecond time in
// in_tdata. Every input transaction returns exactly one output transaction
// holding the read byte, the commit request and the dirty flag after it.
// Timing: an accepted input is captured with a registered read of the byte
// memory, then passes through the execute state, where the result is
// registered, and out_tvalid rises in the respond state. The next item is
// taken in the idle state after that, so none is taken while one is in flight.
// The next item is taken only after the result has been accepted, so a
// stalled receiver (out_tready low) holds the result and in_tready stays low.
// After reset the store is cleared to 0xFF, one entry per cycle: in_tready
// stays low until every entry is cleared. Dirty flag and recorded times reset to 0,
// debounce_ms to 250 and max_defer_ms to 1500. Configuration writes are taken
// at any time, including the clearing pass, and should be made while idle.
// ----------------------------------------------------------------------------
module byte_store_deferred_commit #(
  parameter int STORE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // address[15:0], write_data[23:16], now_ms[55:24]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // read_data[7:0], commit_now[8], dirty_after[9], zero pad
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import bsdc_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_sts_t  sts;
  logic [7:0] res_read_data;
  logic       res_commit;
  logic       res_dirty;

  bsdc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  bsdc_dpath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_cmd        (cmd_t'(in_tuser)),
    .in_addr       (in_tdata[15:0]),
    .in_wdata      (in_tdata[23:16]),
    .in_now        (in_tdata[55:24]),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .res_read_data (res_read_data),
    .res_commit    (res_commit),
    .res_dirty     (res_dirty)
  );

  assign out_tdata = {6'd0, res_dirty, res_commit, res_read_data};

endmodule
